// ===== design/hpa_pkg.sv =====
// Shared types, constants and the helper function of the handle pool allocator.
package hpa_pkg;

    localparam int DEF_POOL_SLOTS = 64;

    localparam int CMD_W        = 3;
    localparam int HANDLE_W     = 20;
    localparam int TAG_W        = 4;
    localparam int SLOT_FIELD_W = 6;
    localparam int COUNT_W      = 7;
    localparam int SEQ_W        = 16;

    localparam logic [CMD_W-1:0] CMD_INIT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIND    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    typedef struct packed {
        logic load_req;
        logic res_clear;
        logic init;
        logic pop;
        logic alloc_wr;
        logic step;
        logic res_empty;
        logic release_slot;
        logic res_tick;
        logic scan_start;
        logic scan_next;
        logic scan_hit_res;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             top_zero;
        logic             handle_zero;
        logic             scan_hit;
        logic             scan_last;
        logic             out_free;
    } t_dp_status;

    // The low sixteen bits advance and skip zero; the tag bits are dropped.
    function automatic logic [HANDLE_W-1:0] f_counter_step(input logic [HANDLE_W-1:0] cur);
        logic [SEQ_W-1:0] low;
        low = cur[SEQ_W-1:0] + 16'd1;
        if (low == '0) begin
            low = 16'd1;
        end
        return {{(HANDLE_W-SEQ_W){1'b0}}, low};
    endfunction

endpackage

// ===== design/handle_pool_allocator_unit.sv =====
// Top level of the handle pool allocator: controller and datapath.
// Init, release, tick and unknown requests pass from decode to the response state, which loads the output register.
// Allocate on an empty stack answers from decode; otherwise it waits in the allocate state on the free stack read.
// Find scans one slot per cycle and stops at the first hit or the last slot; a zero handle skips the scan.
// The next request is taken once the result has moved into the output register; a full output register holds it back.
// Reset is synchronous and active low; the free stack is full at once, with no clearing pass.
module handle_pool_allocator_unit #(
    parameter int POOL_SLOTS = hpa_pkg::DEF_POOL_SLOTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hpa_pkg::TAG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [hpa_pkg::CMD_W-1:0]         i_command,
    input  logic [hpa_pkg::HANDLE_W-1:0]      i_handle,
    input  logic [hpa_pkg::SLOT_FIELD_W-1:0]  i_slot,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_ok,
    output logic [hpa_pkg::SLOT_FIELD_W-1:0]  o_slot_out,
    output logic [hpa_pkg::HANDLE_W-1:0]      o_handle_out,
    output logic                              o_pool_empty,
    output logic [hpa_pkg::COUNT_W-1:0]       o_active_count
);
    import hpa_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    hpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    hpa_datapath #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_handle       (i_handle),
        .i_slot         (i_slot),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_ok           (o_ok),
        .o_slot_out     (o_slot_out),
        .o_handle_out   (o_handle_out),
        .o_pool_empty   (o_pool_empty),
        .o_active_count (o_active_count)
    );

endmodule

// ===== design/hpa_ctrl.sv =====
// Controller state machine that sequences one request at a time through the datapath.
module hpa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hpa_pkg::t_dp_status i_status,
    output hpa_pkg::t_dp_cmd    o_cmd
);
    import hpa_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_ALLOC  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.res_clear = 1'b1;
                n_state         = S_RESP;
                case (i_status.cmd)
                    CMD_INIT: begin
                        o_cmd.init = 1'b1;
                    end
                    CMD_ALLOC: begin
                        if (i_status.top_zero) begin
                            o_cmd.step      = 1'b1;
                            o_cmd.res_empty = 1'b1;
                        end else begin
                            o_cmd.pop = 1'b1;
                            n_state   = S_ALLOC;
                        end
                    end
                    CMD_FIND: begin
                        if (!i_status.handle_zero) begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    CMD_RELEASE: begin
                        o_cmd.release_slot = 1'b1;
                    end
                    CMD_TICK: begin
                        o_cmd.res_tick = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_ALLOC: begin
                o_cmd.alloc_wr = 1'b1;
                n_state        = S_RESP;
            end
            S_SCAN: begin
                if (i_status.scan_hit) begin
                    o_cmd.scan_hit_res = 1'b1;
                    n_state            = S_RESP;
                end else if (i_status.scan_last) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/hpa_datapath.sv =====
// Datapath with the free stack, slot handle memory, active marks, counters and result register.
module hpa_datapath #(
    parameter int POOL_SLOTS = hpa_pkg::DEF_POOL_SLOTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hpa_pkg::t_dp_cmd                  i_cmd,
    output hpa_pkg::t_dp_status               o_status,
    input  logic                              i_cfg_we,
    input  logic [hpa_pkg::TAG_W-1:0]         i_cfg_data,
    input  logic [hpa_pkg::CMD_W-1:0]         i_command,
    input  logic [hpa_pkg::HANDLE_W-1:0]      i_handle,
    input  logic [hpa_pkg::SLOT_FIELD_W-1:0]  i_slot,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_ok,
    output logic [hpa_pkg::SLOT_FIELD_W-1:0]  o_slot_out,
    output logic [hpa_pkg::HANDLE_W-1:0]      o_handle_out,
    output logic                              o_pool_empty,
    output logic [hpa_pkg::COUNT_W-1:0]       o_active_count
);
    import hpa_pkg::*;

    localparam int SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
    localparam logic [CNT_W-1:0]  FULL_TOP  = CNT_W'(POOL_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_SLOTS - 1);

    logic [SLOT_W-1:0]   m_stack  [POOL_SLOTS];
    logic [HANDLE_W-1:0] m_handle [POOL_SLOTS];

    logic [CMD_W-1:0]        r_req_cmd;
    logic [HANDLE_W-1:0]     r_req_handle;
    logic [SLOT_FIELD_W-1:0] r_req_slot;
    logic [TAG_W-1:0]        r_pool_tag;
    logic [HANDLE_W-1:0]     r_counter;
    logic [CNT_W-1:0]        r_top;
    logic [CNT_W-1:0]        r_wmark;
    logic [POOL_SLOTS-1:0]   r_active;
    logic [CNT_W-1:0]        r_count;
    logic                    r_pop_orig;
    logic [SLOT_W-1:0]       r_pop_idx;
    logic [SLOT_W-1:0]       r_stack_rd;
    logic [HANDLE_W-1:0]     r_hdl_rd;
    logic [SLOT_W-1:0]       r_scan_idx;

    logic                    r_res_ok;
    logic [SLOT_FIELD_W-1:0] r_res_slot;
    logic [HANDLE_W-1:0]     r_res_handle;
    logic                    r_res_empty;
    logic [COUNT_W-1:0]      r_res_count;

    logic                    r_out_valid;
    logic                    r_out_ok;
    logic [SLOT_FIELD_W-1:0] r_out_slot;
    logic [HANDLE_W-1:0]     r_out_handle;
    logic                    r_out_empty;
    logic [COUNT_W-1:0]      r_out_count;

    logic [CNT_W-1:0]   pop_top;
    logic [SLOT_W-1:0]  pop_idx;
    logic [SLOT_W-1:0]  alloc_slot;
    logic [SLOT_W-1:0]  rel_idx;
    logic               rel_ok;
    logic [SLOT_W-1:0]  hdl_rd_addr;
    logic               scan_hit;
    logic               out_free;
    logic [COUNT_W-1:0] tick_count;

    assign pop_top     = r_top - CNT_W'(1);
    assign pop_idx     = pop_top[SLOT_W-1:0];
    assign alloc_slot  = r_pop_orig ? (LAST_SLOT - r_pop_idx) : r_stack_rd;
    assign rel_idx     = SLOT_W'(r_req_slot);
    assign rel_ok      = (32'(r_req_slot) < POOL_SLOTS) && r_active[rel_idx]
                         && (r_top < FULL_TOP);
    assign hdl_rd_addr = i_cmd.scan_start ? '0 : (r_scan_idx + SLOT_W'(1));
    assign scan_hit    = r_active[r_scan_idx] && (r_hdl_rd == r_req_handle);
    assign out_free    = !r_out_valid || i_out_ready;
    assign tick_count  = (32'(r_count) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(r_count);

    assign o_status.cmd         = r_req_cmd;
    assign o_status.top_zero    = (r_top == '0);
    assign o_status.handle_zero = (r_req_handle == '0);
    assign o_status.scan_hit    = scan_hit;
    assign o_status.scan_last   = (r_scan_idx == LAST_SLOT);
    assign o_status.out_free    = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_stack_rd <= m_stack[pop_idx];
        end
        if (i_cmd.release_slot && rel_ok) begin
            m_stack[r_top[SLOT_W-1:0]] <= rel_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_wr) begin
            m_handle[alloc_slot] <= r_counter;
        end
        if (i_cmd.scan_start || i_cmd.scan_next) begin
            r_hdl_rd <= m_handle[hdl_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req_cmd    <= i_command;
            r_req_handle <= i_handle;
            r_req_slot   <= i_slot;
        end
        if (i_cmd.pop) begin
            r_pop_idx  <= pop_idx;
            r_pop_orig <= (pop_top < r_wmark);
        end
        if (i_cmd.scan_start || i_cmd.scan_next) begin
            r_scan_idx <= hdl_rd_addr;
        end
        if (i_cmd.res_clear) begin
            r_res_ok     <= 1'b0;
            r_res_slot   <= '0;
            r_res_handle <= '0;
            r_res_empty  <= i_cmd.res_empty;
            r_res_count  <= i_cmd.res_tick ? tick_count : '0;
        end
        if (i_cmd.alloc_wr) begin
            r_res_ok     <= 1'b1;
            r_res_slot   <= SLOT_FIELD_W'(alloc_slot);
            r_res_handle <= r_counter;
        end
        if (i_cmd.scan_hit_res) begin
            r_res_ok     <= 1'b1;
            r_res_slot   <= SLOT_FIELD_W'(r_scan_idx);
            r_res_handle <= r_req_handle;
        end
        if (i_cmd.out_load) begin
            r_out_ok     <= r_res_ok;
            r_out_slot   <= r_res_slot;
            r_out_handle <= r_res_handle;
            r_out_empty  <= r_res_empty;
            r_out_count  <= r_res_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_tag  <= '0;
            r_counter   <= '0;
            r_top       <= FULL_TOP;
            r_wmark     <= FULL_TOP;
            r_active    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pool_tag <= i_cfg_data;
            end
            if (i_cmd.init) begin
                r_top     <= FULL_TOP;
                r_wmark   <= FULL_TOP;
                r_active  <= '0;
                r_count   <= '0;
                r_counter <= {r_pool_tag, {(SEQ_W-1){1'b0}}, 1'b1};
            end
            if (i_cmd.pop) begin
                r_top <= pop_top;
                if (pop_top < r_wmark) begin
                    r_wmark <= pop_top;
                end
            end
            if (i_cmd.alloc_wr) begin
                r_active[alloc_slot] <= 1'b1;
                r_count              <= r_count + CNT_W'(1);
            end
            if (i_cmd.alloc_wr || i_cmd.step) begin
                r_counter <= f_counter_step(r_counter);
            end
            if (i_cmd.release_slot && rel_ok) begin
                r_active[rel_idx] <= 1'b0;
                r_top             <= r_top + CNT_W'(1);
                r_count           <= r_count - CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_ok           = r_out_ok;
    assign o_slot_out     = r_out_slot;
    assign o_handle_out   = r_out_handle;
    assign o_pool_empty   = r_out_empty;
    assign o_active_count = r_out_count;

`ifndef SYNTH
    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= FULL_TOP)
        else $error("free stack top beyond pool size");

    a_wmark_below_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wmark <= r_top)
        else $error("stack watermark above stack top");

    a_count_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) + 32'(r_top) + 32'(i_cmd.alloc_wr)) == POOL_SLOTS)
        else $error("active count and free count disagree");

    a_counter_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.alloc_wr || i_cmd.step) |=> (r_counter[SEQ_W-1:0] != '0))
        else $error("handle counter advanced to zero");
`endif

endmodule

// ===== sim/tb_handle_pool_allocator_unit.sv =====
// Testbench for the handle pool allocator: directed table, random traffic and a pool exhaustion run.
module tb_handle_pool_allocator_unit;
    import hpa_pkg::*;

    localparam int SLOTS       = DEF_POOL_SLOTS;
    localparam int TAIL_CYCLES = SLOTS + 8;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 350;

    localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic                    ok;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [HANDLE_W-1:0]     handle;
        logic                    empty;
        logic [COUNT_W-1:0]      count;
    } t_pool_reply;

    typedef enum logic {ROW_REQ, ROW_TAG} t_row_kind;

    typedef struct packed {
        t_row_kind               kind;
        logic [CMD_W-1:0]        cmd;
        logic [HANDLE_W-1:0]     handle;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [TAG_W-1:0]        tag;
        logic                    typed;
        t_pool_reply             want;
    } t_stim_row;

    localparam t_pool_reply NO_REPLY = '0;

    t_stim_row directed_rows [25] = '{
        '{ROW_REQ, CMD_ALLOC,   20'h00000, 6'd0,  4'd0,  1'b1, '{1'b1, 6'd0, 20'h00000, 1'b0, 7'd0}},
        '{ROW_REQ, CMD_FIND,    20'h00000, 6'd0,  4'd0,  1'b1, NO_REPLY},
        '{ROW_REQ, CMD_TICK,    20'h00000, 6'd0,  4'd0,  1'b1, '{1'b0, 6'd0, 20'h00000, 1'b0, 7'd1}},
        '{ROW_REQ, CMD_RELEASE, 20'h00000, 6'd63, 4'd0,  1'b1, NO_REPLY},
        '{ROW_REQ, CMD_SPARE_5, 20'hFFFFF, 6'd63, 4'd0,  1'b1, NO_REPLY},
        '{ROW_REQ, CMD_SPARE_6, 20'h00000, 6'd0,  4'd0,  1'b1, NO_REPLY},
        '{ROW_REQ, CMD_SPARE_7, 20'hFFFFF, 6'd63, 4'd0,  1'b1, NO_REPLY},
        '{ROW_TAG, CMD_INIT,    20'h00000, 6'd0,  4'd15, 1'b0, NO_REPLY},
        '{ROW_REQ, CMD_INIT,    20'hFFFFF, 6'd63, 4'd0,  1'b1, NO_REPLY},
        '{ROW_REQ, CMD_TICK,    20'h00000, 6'd0,  4'd0,  1'b1, NO_REPLY},
        '{ROW_REQ, CMD_ALLOC,   20'h00000, 6'd0,  4'd0,  1'b1, '{1'b1, 6'd0, 20'hF0001, 1'b0, 7'd0}},
        '{ROW_REQ, CMD_ALLOC,   20'h00000, 6'd0,  4'd0,  1'b1, '{1'b1, 6'd1, 20'h00002, 1'b0, 7'd0}},
        '{ROW_REQ, CMD_FIND,    20'hF0001, 6'd0,  4'd0,  1'b1, '{1'b1, 6'd0, 20'hF0001, 1'b0, 7'd0}},
        '{ROW_REQ, CMD_FIND,    20'hFFFFF, 6'd0,  4'd0,  1'b1, NO_REPLY},
        '{ROW_REQ, CMD_FIND,    20'h00002, 6'd0,  4'd0,  1'b1, '{1'b1, 6'd1, 20'h00002, 1'b0, 7'd0}},
        '{ROW_REQ, CMD_RELEASE, 20'h00000, 6'd0,  4'd0,  1'b1, NO_REPLY},
        '{ROW_REQ, CMD_FIND,    20'hF0001, 6'd0,  4'd0,  1'b1, NO_REPLY},
        '{ROW_REQ, CMD_RELEASE, 20'h00000, 6'd0,  4'd0,  1'b1, NO_REPLY},
        '{ROW_REQ, CMD_ALLOC,   20'h00000, 6'd0,  4'd0,  1'b1, '{1'b1, 6'd0, 20'h00003, 1'b0, 7'd0}},
        '{ROW_REQ, CMD_ALLOC,   20'h00000, 6'd0,  4'd0,  1'b0, NO_REPLY},
        '{ROW_REQ, CMD_TICK,    20'h00000, 6'd0,  4'd0,  1'b1, '{1'b0, 6'd0, 20'h00000, 1'b0, 7'd3}},
        '{ROW_TAG, CMD_INIT,    20'h00000, 6'd0,  4'd0,  1'b0, NO_REPLY},
        '{ROW_REQ, CMD_INIT,    20'h00000, 6'd0,  4'd0,  1'b1, NO_REPLY},
        '{ROW_REQ, CMD_ALLOC,   20'h00000, 6'd0,  4'd0,  1'b1, '{1'b1, 6'd0, 20'h00001, 1'b0, 7'd0}},
        '{ROW_REQ, CMD_FIND,    20'h00002, 6'd0,  4'd0,  1'b1, NO_REPLY}
    };

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [TAG_W-1:0]        i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [CMD_W-1:0]        i_command;
    logic [HANDLE_W-1:0]     i_handle;
    logic [SLOT_FIELD_W-1:0] i_slot;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic                    o_ok;
    logic [SLOT_FIELD_W-1:0] o_slot_out;
    logic [HANDLE_W-1:0]     o_handle_out;
    logic                    o_pool_empty;
    logic [COUNT_W-1:0]      o_active_count;

    logic [SLOT_FIELD_W-1:0] free_slots [SLOTS];
    int                      free_depth;
    logic [HANDLE_W-1:0]     slot_stamp [SLOTS];
    logic                    slot_live [SLOTS];
    logic [HANDLE_W-1:0]     model_counter;
    logic [TAG_W-1:0]        pool_tag_q;

    t_pool_reply replies_due [$];
    t_pool_reply seen_reply;
    t_pool_reply due_reply;
    int          mismatches = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          rx_hold = 0;

    handle_pool_allocator_unit #(
        .POOL_SLOTS(SLOTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_command(i_command),
        .i_handle(i_handle),
        .i_slot(i_slot),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_ok(o_ok),
        .o_slot_out(o_slot_out),
        .o_handle_out(o_handle_out),
        .o_pool_empty(o_pool_empty),
        .o_active_count(o_active_count)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    initial begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic void refill_free_slots();
        for (int i = 0; i < SLOTS; i++) begin
            free_slots[i] = SLOT_FIELD_W'(SLOTS - 1 - i);
            slot_live[i] = 1'b0;
        end
        free_depth = SLOTS;
    endfunction

    function automatic t_pool_reply compute_pool_reply(input logic [CMD_W-1:0] cmd,
                                                       input logic [HANDLE_W-1:0] h,
                                                       input logic [SLOT_FIELD_W-1:0] s);
        t_pool_reply             r;
        logic [SLOT_FIELD_W-1:0] taken;
        int                      n;
        r = '0;
        n = 0;
        case (cmd)
            CMD_INIT: begin
                refill_free_slots();
                model_counter = {pool_tag_q, SEQ_W'(1)};
            end
            CMD_ALLOC: begin
                if (free_depth > 0) begin
                    free_depth--;
                    taken = free_slots[free_depth];
                    slot_live[taken] = 1'b1;
                    slot_stamp[taken] = model_counter;
                    r.ok = 1'b1;
                    r.slot = taken;
                    r.handle = model_counter;
                end else begin
                    r.empty = 1'b1;
                end
                model_counter = {{(HANDLE_W-SEQ_W){1'b0}},
                                 model_counter[SEQ_W-1:0] + SEQ_W'(1)};
                if (model_counter == '0) begin
                    model_counter = HANDLE_W'(1);
                end
            end
            CMD_FIND: begin
                if (h != '0) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_live[i] && slot_stamp[i] == h) begin
                            r.ok = 1'b1;
                            r.slot = SLOT_FIELD_W'(i);
                            r.handle = h;
                            break;
                        end
                    end
                end
            end
            CMD_RELEASE: begin
                if (slot_live[s] && free_depth < SLOTS) begin
                    slot_live[s] = 1'b0;
                    free_slots[free_depth] = s;
                    free_depth++;
                end
            end
            CMD_TICK: begin
                foreach (slot_live[i]) begin
                    if (slot_live[i]) begin
                        n++;
                    end
                end
                r.count = (n > COUNT_MAX) ? COUNT_MAX : COUNT_W'(n);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void pick_request(input logic allow_init,
                                         output logic [CMD_W-1:0] cmd,
                                         output logic [HANDLE_W-1:0] h,
                                         output logic [SLOT_FIELD_W-1:0] s);
        int roll;
        int live [$];
        roll = $urandom_range(99);
        h = HANDLE_W'($urandom);
        s = SLOT_FIELD_W'($urandom);
        foreach (slot_live[i]) begin
            if (slot_live[i]) begin
                live.push_back(i);
            end
        end
        if (roll < 3) begin
            cmd = allow_init ? CMD_INIT : CMD_TICK;
        end else if (roll < 40) begin
            cmd = CMD_ALLOC;
        end else if (roll < 64) begin
            cmd = CMD_RELEASE;
            if (live.size() > 0 && $urandom_range(4) != 0) begin
                s = SLOT_FIELD_W'(live[$urandom_range(live.size() - 1)]);
            end
        end else if (roll < 90) begin
            cmd = CMD_FIND;
            roll = $urandom_range(9);
            if (roll < 7 && live.size() > 0) begin
                h = slot_stamp[live[$urandom_range(live.size() - 1)]];
            end else if (roll == 7) begin
                h = '0;
            end
        end else if (roll < 96) begin
            cmd = CMD_TICK;
        end else begin
            case ($urandom_range(2))
                0: cmd = CMD_SPARE_5;
                1: cmd = CMD_SPARE_6;
                default: cmd = CMD_SPARE_7;
            endcase
        end
    endfunction

    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] h,
                                input logic [SLOT_FIELD_W-1:0] s, input logic typed,
                                input t_pool_reply want);
        t_pool_reply predicted;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_command = cmd;
        i_handle = h;
        i_slot = s;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        predicted = compute_pool_reply(cmd, h, s);
        replies_due.push_back(typed ? want : predicted);
    endtask

    task automatic drain_replies();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (replies_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_pool_tag(input logic [TAG_W-1:0] tag);
        drain_replies();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = tag;
        pool_tag_q = tag;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Allocates past the pool size, then mixes random requests with init left out.
    task automatic run_pool_exhaust();
        logic [CMD_W-1:0]        cmd;
        logic [HANDLE_W-1:0]     h;
        logic [SLOT_FIELD_W-1:0] s;
        write_pool_tag(TAG_W'($urandom));
        send_request(CMD_INIT, '0, '0, 1'b0, NO_REPLY);
        repeat (SLOTS + 6) send_request(CMD_ALLOC, '0, '0, 1'b0, NO_REPLY);
        repeat (160) begin
            pick_request(1'b0, cmd, h, s);
            send_request(cmd, h, s, 1'b0, NO_REPLY);
        end
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_out_ready = 1'b0;
                rx_hold--;
            end else begin
                i_out_ready = ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_reply = '{o_ok, o_slot_out, o_handle_out, o_pool_empty, o_active_count};
            if (replies_due.size() == 0) begin
                note_failure($sformatf(
                    "unexpected reply ok=%0d slot=%0d handle=%h empty=%0d cnt=%0d",
                    o_ok, o_slot_out, o_handle_out, o_pool_empty, o_active_count));
            end else begin
                due_reply = replies_due.pop_front();
                if (seen_reply.ok !== due_reply.ok || seen_reply.slot !== due_reply.slot ||
                    seen_reply.handle !== due_reply.handle ||
                    seen_reply.empty !== due_reply.empty ||
                    seen_reply.count !== due_reply.count) begin
                    note_failure({
                        $sformatf("reply mismatch: exp ok=%0d slot=%0d handle=%h empty=%0d cnt=%0d",
                                  due_reply.ok, due_reply.slot, due_reply.handle,
                                  due_reply.empty, due_reply.count),
                        $sformatf(", got ok=%0d slot=%0d handle=%h empty=%0d cnt=%0d",
                                  seen_reply.ok, seen_reply.slot, seen_reply.handle,
                                  seen_reply.empty, seen_reply.count)});
                end
            end
        end
    end

    initial begin
        logic [CMD_W-1:0]        cmd;
        logic [HANDLE_W-1:0]     h;
        logic [SLOT_FIELD_W-1:0] s;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_command = CMD_INIT;
        i_handle = '0;
        i_slot = '0;
        refill_free_slots();
        foreach (slot_stamp[i]) begin
            slot_stamp[i] = '0;
        end
        model_counter = '0;
        pool_tag_q = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_TAG) begin
                write_pool_tag(directed_rows[r].tag);
            end else begin
                send_request(directed_rows[r].cmd, directed_rows[r].handle,
                             directed_rows[r].slot, directed_rows[r].typed,
                             directed_rows[r].want);
            end
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_pool_tag('0);
                1: write_pool_tag('1);
                default: write_pool_tag(TAG_W'($urandom));
            endcase
            tx_idle_pct = (phase == 1) ? 59 : (phase == 3) ? 17 : 0;
            rx_stall_pct = (phase == 2) ? 59 : (phase == 3) ? 17 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 1 && n == 20) begin
                    rx_hold = 400;
                end
                if (phase == 2 && n == PHASE_ITEMS / 2) begin
                    drain_replies();
                end
                pick_request(1'b1, cmd, h, s);
                send_request(cmd, h, s, 1'b0, NO_REPLY);
            end
        end

        tx_idle_pct = 0;
        rx_stall_pct = 0;
        run_pool_exhaust();
        drain_replies();

        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
